// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/plb_pkg.sv =====
// Package with shared constants and types of the price level book.
`timescale 1ns / 1ps
package plb_pkg;
   localparam int LEVELS_DEFAULT = 64;
   localparam int PRICE_W = 32;
   localparam int QTY_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SHOW
   } state_type;

   // Command broadcast to all cells of one side.
   typedef struct packed {
      logic              apply;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cmd_type;
endpackage

// ===== design/plb_cell.sv =====
// One book cell: holds one price level and takes part in the sorted shift.
`timescale 1ns / 1ps
module plb_cell
   import plb_pkg::*;
#(
   parameter bit WANT_HIGH = 1'b1
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               any_hit,
   input  logic               side_full,
   input  logic               prev_used,
   input  logic [PRICE_W-1:0] prev_price,
   input  logic [QTY_W-1:0]   prev_qty,
   input  logic               prev_ins,
   input  logic               next_used,
   input  logic [PRICE_W-1:0] next_price,
   input  logic [QTY_W-1:0]   next_qty,
   output logic               used,
   output logic [PRICE_W-1:0] price,
   output logic [QTY_W-1:0]   qty,
   output logic               ins_here,
   output logic               hit
);
   logic               used_ff, used_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic               better;
   logic               del_here;

   assign used  = used_ff;
   assign price = price_ff;
   assign qty   = qty_ff;
   assign hit   = used_ff && (price_ff == cmd.price);
   assign better = WANT_HIGH ? (cmd.price > price_ff) : (cmd.price < price_ff);
   // The new level goes here when this cell is free or the new price ranks ahead.
   assign ins_here = !used_ff || (used_ff && better);
   // The chain is sorted, so the hit cell and every cell behind it close the gap.
   assign del_here = any_hit && (hit || ins_here);

   always_comb begin
      used_in  = used_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      if (cmd.apply) begin
         if (cmd.qty == '0) begin
            if (del_here) begin
               used_in  = next_used;
               price_in = next_price;
               qty_in   = next_qty;
            end
         end else if (hit) begin
            qty_in = cmd.qty;
         end else if (!any_hit && !side_full) begin
            if (prev_ins) begin
               used_in  = prev_used;
               price_in = prev_price;
               qty_in   = prev_qty;
            end else if (ins_here) begin
               used_in  = 1'b1;
               price_in = cmd.price;
               qty_in   = cmd.qty;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end
endmodule

// ===== design/plb_side.sv =====
// Sorted chain of cells for one side of the book.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plb_side
   import plb_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT,
   parameter bit WANT_HIGH = 1'b1
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output logic               full,
   output logic               present,
   output logic               best_valid,
   output logic [PRICE_W-1:0] best_price
);
   logic [LEVELS-1:0]  used, ins, hit;
   logic [PRICE_W-1:0] price [LEVELS];
   logic [QTY_W-1:0]   qty [LEVELS];

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      logic               p_used, p_ins, n_used;
      logic [PRICE_W-1:0] p_price, n_price;
      logic [QTY_W-1:0]   p_qty, n_qty;
      if (i == 0) begin : g_first
         assign p_used = 1'b0;
         assign p_price = '0;
         assign p_qty = '0;
         assign p_ins = 1'b0;
      end else begin : g_mid
         assign p_used = used[i-1];
         assign p_price = price[i-1];
         assign p_qty = qty[i-1];
         assign p_ins = ins[i-1];
      end
      if (i == LEVELS - 1) begin : g_last
         assign n_used = 1'b0;
         assign n_price = '0;
         assign n_qty = '0;
      end else begin : g_inner
         assign n_used = used[i+1];
         assign n_price = price[i+1];
         assign n_qty = qty[i+1];
      end
      // A hit or a full side blocks the insertion shift.
      plb_cell #(.WANT_HIGH(WANT_HIGH)) u_cell (
         .clock, .reset, .cmd(cmd), .any_hit(present), .side_full(full),
         .prev_used(p_used), .prev_price(p_price), .prev_qty(p_qty),
         .prev_ins(p_ins),
         .next_used(n_used), .next_price(n_price), .next_qty(n_qty),
         .used(used[i]), .price(price[i]), .qty(qty[i]),
         .ins_here(ins[i]), .hit(hit[i])
      );
   end

   assign full       = used[LEVELS-1];
   assign present    = |hit;
   assign best_valid = used[0];
   assign best_price = used[0] ? price[0] : '0;

   `ASSERT_NEXT(a_full_stays, clock, reset, full && cmd.qty != '0 && cmd.apply, used[0])
   `ASSERT_IMPL(a_best_first, clock, reset, used[1], used[0])
   `ASSERT_IMPL(a_one_hit, clock, reset, 1'b1, $onehot0(hit))
endmodule

// ===== design/price_level_book_top.sv =====
// Top level of the price level book with its stream ports.
`timescale 1ns / 1ps
// Channel | Direction | Payload
// req_    | in        | side_sell, level_price, level_qty
// rsp_    | out       | book top, spread, doubled mid, status
// A transaction is accepted in ST_IDLE, applied to the cell chain in ST_APPLY and
// its result registered in ST_SHOW; no new transaction is accepted until the state
// returns to ST_IDLE, and the cell chain shifts during ST_APPLY.
// Reset clears all used bits at once; no clearing pass is needed.
// A result not yet taken holds the next transaction in its last cycle until rsp_tready.
`include "assert_macros.svh"
module price_level_book_top
   import plb_pkg::*;
#(
   parameter int LEVELS_PER_SIDE = LEVELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // side_sell[0], level_price[32:1], level_qty[64:33], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // bid_valid[0], best_bid[32:1], ask_valid[33], best_ask[65:34], quote_valid[66],
   // spread_ticks[99:67], mid_doubled[132:100], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic                  rsp_tuser
);
   state_type          state_ff, state_in;
   logic               sell_ff, sell_in;
   logic [PRICE_W-1:0] px_ff, px_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic               status_ff, status_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   cmd_type            bid_cmd, ask_cmd;
   logic               bid_full, bid_pres, bid_v, ask_full, ask_pres, ask_v, qv;
   logic [PRICE_W-1:0] bid_p, ask_p;
   logic [32:0]        spread, mid;

   always_comb begin
      state_in   = state_ff;
      sell_in    = sell_ff;
      px_in      = px_ff;
      qty_in     = qty_ff;
      status_in  = status_ff;
      data_in    = data_ff;
      req_tready = 1'b0;
      bid_cmd    = '{apply: 1'b0, price: px_ff, qty: qty_ff};
      ask_cmd    = bid_cmd;
      qv     = bid_v && ask_v;
      spread = qv ? ({1'b0, ask_p} - {1'b0, bid_p}) : '0;
      mid    = qv ? ({1'b0, ask_p} + {1'b0, bid_p}) : '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sell_in  = req_tdata[0];
               px_in    = req_tdata[32:1];
               qty_in   = req_tdata[64:33];
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            bid_cmd.apply = !sell_ff;
            ask_cmd.apply = sell_ff;
            status_in = (qty_ff != '0) && (sell_ff ? (ask_full && !ask_pres)
                                                    : (bid_full && !bid_pres));
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            data_in = '0;
            data_in[132:0] = {mid, spread, qv, ask_p, ask_v, bid_p, bid_v};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic out_v_ff, out_v_in;
   logic out_s_ff;
   always_comb begin
      out_v_in = out_v_ff;
      if (rsp_tready) out_v_in = 1'b0;
      if (state_ff == ST_SHOW) out_v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else if (!(out_v_ff && !rsp_tready && state_ff == ST_SHOW)) begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      sell_ff   <= sell_in;
      px_ff     <= px_in;
      qty_ff    <= qty_in;
      status_ff <= status_in;
      if (state_ff == ST_SHOW && !(out_v_ff && !rsp_tready)) begin
         data_ff  <= data_in;
         out_s_ff <= status_ff;
      end
   end

   plb_side #(.LEVELS(LEVELS_PER_SIDE), .WANT_HIGH(1'b1)) u_bid (
      .clock, .reset, .cmd(bid_cmd), .full(bid_full), .present(bid_pres),
      .best_valid(bid_v), .best_price(bid_p)
   );
   plb_side #(.LEVELS(LEVELS_PER_SIDE), .WANT_HIGH(1'b0)) u_ask (
      .clock, .reset, .cmd(ask_cmd), .full(ask_full), .present(ask_pres),
      .best_valid(ask_v), .best_price(ask_p)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = out_s_ff;

   `ASSERT_NEXT(a_accept_apply, clock, reset, req_tvalid && req_tready, state_ff == ST_APPLY)
   `ASSERT_IMPL(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `ASSERT_NEXT(a_apply_show, clock, reset, state_ff == ST_APPLY, state_ff == ST_SHOW)
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the price level book top level.
`timescale 1ns / 1ps
module testbench;
   import plb_pkg::*;

   localparam int LEVELS = 64;

   typedef struct packed {
      logic        bid_valid;
      logic [31:0] top_bid;
      logic        ask_valid;
      logic [31:0] top_ask;
      logic        quote_valid;
      logic [32:0] spread_ticks;
      logic [32:0] mid_doubled;
      logic        status;
   } quote_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   logic [31:0] bid_px [LEVELS];
   logic        bid_on [LEVELS];
   logic [31:0] ask_px [LEVELS];
   logic        ask_on [LEVELS];

   quote_type expected_quotes[$];
   int        mismatch_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        hold_cycles = 0;

   price_level_book_top #(.LEVELS_PER_SIDE(LEVELS)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic quote_type book_update(input logic sell, input logic [31:0] px,
                                             input logic [31:0] qty);
      quote_type q;
      int hit;
      int free_slot;
      logic [31:0] bb;
      logic [31:0] ba;
      q = '0;
      hit = -1;
      free_slot = -1;
      bb = '0;
      ba = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (sell ? ask_on[i] : bid_on[i]) begin
            if ((sell ? ask_px[i] : bid_px[i]) == px && hit < 0) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (qty == 0) begin
         if (hit >= 0) begin
            if (sell) ask_on[hit] = 1'b0;
            else bid_on[hit] = 1'b0;
         end
      end else if (hit < 0) begin
         if (free_slot < 0) begin
            q.status = 1'b1;
         end else if (sell) begin
            ask_px[free_slot] = px;
            ask_on[free_slot] = 1'b1;
         end else begin
            bid_px[free_slot] = px;
            bid_on[free_slot] = 1'b1;
         end
      end
      for (int i = 0; i < LEVELS; i++) begin
         if (bid_on[i] && (!q.bid_valid || bid_px[i] > bb)) begin
            bb = bid_px[i];
            q.bid_valid = 1'b1;
         end
         if (ask_on[i] && (!q.ask_valid || ask_px[i] < ba)) begin
            ba = ask_px[i];
            q.ask_valid = 1'b1;
         end
      end
      q.top_bid = bb;
      q.top_ask = ba;
      q.quote_valid = q.bid_valid && q.ask_valid;
      if (q.quote_valid) begin
         q.spread_ticks = {1'b0, ba} - {1'b0, bb};
         q.mid_doubled = {1'b0, ba} + {1'b0, bb};
      end
      return q;
   endfunction

   task automatic send_update(input logic sell, input logic [31:0] px, input logic [31:0] qty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, qty, px, sell};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_quotes.insert(expected_quotes.size(), book_update(sell, px, qty));
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      quote_type got;
      quote_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[33], rsp_tdata[65:34],
                 rsp_tdata[66], rsp_tdata[99:67], rsp_tdata[132:100], rsp_tuser};
         if (expected_quotes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected quote %h", got);
         end else begin
            want = expected_quotes.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("quote mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   task automatic test_directed;
      send_update(1'b0, 32'd0, 32'd5);
      send_update(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_update(1'b0, 32'hFFFFFFFF, 32'd1);
      send_update(1'b1, 32'd0, 32'd7);
      send_update(1'b1, 32'd0, 32'd9);
      send_update(1'b0, 32'hFFFFFFFF, 32'd0);
      send_update(1'b0, 32'd1234, 32'd0);
      send_update(1'b1, 32'd0, 32'd0);
      send_update(1'b1, 32'hFFFFFFFF, 32'd0);
      send_update(1'b0, 32'd0, 32'd0);
      send_update(1'b0, 32'h55555555, 32'hAAAAAAAA);
      send_update(1'b1, 32'hAAAAAAAA, 32'h55555555);
      send_update(1'b1, 32'h55555555, 32'd3);
   endtask

   task automatic test_full_sides;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < LEVELS + 3; i++) send_update(s[0], 32'd1000 + i, 32'd10 + i);
         for (int i = 0; i < LEVELS + 3; i++) send_update(s[0], 32'd1000 + i, 32'd0);
      end
   endtask

   task automatic test_random(input int count);
      logic [31:0] px;
      logic [31:0] qty;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: px = $urandom();
            default: px = 32'd5000 + $urandom_range(40);
         endcase
         qty = ($urandom_range(2) == 0) ? 32'd0 : $urandom();
         send_update(1'($urandom_range(1)), px, qty);
      end
   endtask

   task automatic test_backpressure;
      hold_cycles <= 200;
      test_random(20);
   endtask

   initial begin
      foreach (bid_on[i]) begin
         bid_on[i] = 1'b0;
         ask_on[i] = 1'b0;
         bid_px[i] = '0;
         ask_px[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_sides();
      test_random(100);
      send_idle_pct = 68;
      test_random(150);
      send_idle_pct = 0;
      recv_stall_pct = 68;
      test_random(150);
      send_idle_pct = 32;
      recv_stall_pct = 32;
      test_random(150);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_quotes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_quotes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/plb_pkg.sv
design/plb_cell.sv
design/plb_side.sv
design/price_level_book_top.sv
sim/testbench.sv
